[hdl/ped_pkg.sv]
// Package for the priority event dispatcher: codes, constants, result type.
`timescale 1ns / 1ps
package ped_pkg;

    // Default configuration
    localparam int PRIORITIES_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int EVENT_BITS_DEF  = 8;

    // Fixed port widths
    localparam int CMD_W      = 2;
    localparam int PRIO_REQ_W = 5;
    localparam int EVENT_ID_W = 8;
    localparam int STATUS_W   = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_POST       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POST_AHEAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FETCH      = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FETCHED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    // Result status carried from the queue control to the output register
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PRIO_REQ_W-1:0] out_priority;
        logic                  any_ready;
    } t_result;

endpackage

[hdl/ped_event_store.sv]
// Event storage memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ped_event_store #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/ped_queue_ctrl.sv]
// Queue control: ready bitmap, per-slot ring head and count, priority select.
`timescale 1ns / 1ps
module ped_queue_ctrl #(
    parameter int PRIORITIES  = 32,
    parameter int QUEUE_DEPTH = 8,
    parameter int EVENT_BITS  = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic [ped_pkg::CMD_W-1:0]                i_command,
    input  logic [ped_pkg::PRIO_REQ_W-1:0]           i_priority_req,
    input  logic [ped_pkg::EVENT_ID_W-1:0]           i_event_id,
    output logic                                     o_wr_en,
    output logic [$clog2(PRIORITIES*QUEUE_DEPTH)-1:0] o_wr_addr,
    output logic [EVENT_BITS-1:0]                    o_wr_data,
    output logic                                     o_rd_en,
    output logic [$clog2(PRIORITIES*QUEUE_DEPTH)-1:0] o_rd_addr,
    output ped_pkg::t_result                         o_res
);
    import ped_pkg::*;

    localparam int SLOT_W = $clog2(PRIORITIES);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int ADDR_W = $clog2(PRIORITIES * QUEUE_DEPTH);
    localparam int CMP_W  = 8;
    localparam int RQ_W   = (SLOT_W > PRIO_REQ_W) ? SLOT_W : PRIO_REQ_W;
    localparam int EV_W   = (EVENT_BITS > EVENT_ID_W) ? EVENT_BITS : EVENT_ID_W;

    localparam logic [PTR_W-1:0]  LAST_POS  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] DEPTH_A   = ADDR_W'(QUEUE_DEPTH);

    logic [PRIORITIES-1:0] r_ready;
    logic [PRIORITIES-1:0] n_ready;
    logic [PTR_W-1:0]      r_head [PRIORITIES];
    logic [CNT_W-1:0]      r_count [PRIORITIES];

    logic [RQ_W-1:0]       w_req_wide;
    logic [SLOT_W-1:0]     w_slot;
    logic                  w_slot_ok;
    logic [SLOT_W-1:0]     w_sel;
    logic [RQ_W-1:0]       w_sel_wide;
    logic [SLOT_W-1:0]     w_idx;
    logic [PTR_W-1:0]      w_head;
    logic [CNT_W-1:0]      w_count;
    logic [SUM_W-1:0]      w_tail_sum;
    logic [PTR_W-1:0]      w_tail;
    logic [PTR_W-1:0]      w_pos;
    logic [EV_W-1:0]       w_ev_wide;
    logic                  w_state_we;
    logic [PTR_W-1:0]      n_head;
    logic [CNT_W-1:0]      n_count;
    t_result               w_res;

    // Map the requested slot into the slot index range
    assign w_req_wide = RQ_W'(i_priority_req);
    assign w_slot     = w_req_wide[SLOT_W-1:0];
    assign w_slot_ok  = (CMP_W'(i_priority_req) < CMP_W'(PRIORITIES));

    // Select the highest ready slot
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < PRIORITIES; i++) begin
            if (r_ready[i]) begin
                w_sel = SLOT_W'(i);
            end
        end
    end
    assign w_sel_wide = RQ_W'(w_sel);

    // Look up the ring state of the slot this word works on
    assign w_idx   = (i_command == CMD_FETCH) ? w_sel : w_slot;
    assign w_head  = r_head[w_idx];
    assign w_count = r_count[w_idx];

    // Tail position, wrapped into the ring
    assign w_tail_sum = SUM_W'(w_head) + SUM_W'(w_count);
    always_comb begin
        if (w_tail_sum >= DEPTH_SUM) begin
            w_tail = PTR_W'(w_tail_sum - DEPTH_SUM);
        end else begin
            w_tail = PTR_W'(w_tail_sum);
        end
    end

    assign w_ev_wide = EV_W'(i_event_id);

    // Decode the command and work out the next state
    always_comb begin
        n_ready      = r_ready;
        n_head       = w_head;
        n_count      = w_count;
        w_state_we   = 1'b0;
        w_pos        = w_tail;
        o_wr_en      = 1'b0;
        o_rd_en      = 1'b0;
        w_res.status       = ST_EMPTY;
        w_res.out_priority = '0;
        if (i_valid) begin
            case (i_command)
                CMD_POST, CMD_POST_AHEAD: begin
                    if (!w_slot_ok || (w_count == FULL_CNT)) begin
                        w_res.status = ST_DROPPED;
                    end else begin
                        w_res.status = ST_QUEUED;
                        if (i_command == CMD_POST_AHEAD) begin
                            n_head = (w_head == '0) ? LAST_POS : (w_head - PTR_W'(1));
                            w_pos  = n_head;
                        end
                        n_count         = w_count + CNT_W'(1);
                        n_ready[w_slot] = 1'b1;
                        w_state_we      = 1'b1;
                        o_wr_en         = 1'b1;
                    end
                end
                CMD_FETCH: begin
                    if (r_ready != '0) begin
                        w_res.status       = ST_FETCHED;
                        w_res.out_priority = w_sel_wide[PRIO_REQ_W-1:0];
                        n_head  = (w_head == LAST_POS) ? '0 : (w_head + PTR_W'(1));
                        n_count = w_count - CNT_W'(1);
                        if (w_count == CNT_W'(1)) begin
                            n_ready[w_sel] = 1'b0;
                        end
                        w_state_we = 1'b1;
                        o_rd_en    = 1'b1;
                    end
                end
                default: begin
                    w_res.status = ST_EMPTY;
                end
            endcase
        end
        w_res.any_ready = (n_ready != '0);
    end

    assign o_wr_addr = ADDR_W'(w_slot) * DEPTH_A + ADDR_W'(w_pos);
    assign o_wr_data = w_ev_wide[EVENT_BITS-1:0];
    assign o_rd_addr = ADDR_W'(w_sel) * DEPTH_A + ADDR_W'(w_head);
    assign o_res     = w_res;

    // Update bitmap and ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= '0;
            for (int i = 0; i < PRIORITIES; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_ready <= n_ready;
            if (w_state_we) begin
                r_head[w_idx]  <= n_head;
                r_count[w_idx] <= n_count;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fetch_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_command == CMD_FETCH) && (r_ready != '0))
            |-> (w_res.status == ST_FETCHED))
        else $error("fetch with a ready slot did not fetch");

    a_post_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (w_res.status == ST_QUEUED)) |=> r_ready[$past(w_slot)])
        else $error("queued post left its slot not ready");

    a_any_ready_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> ((r_ready != '0) == $past(w_res.any_ready)))
        else $error("any_ready disagrees with the bitmap");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (w_count <= FULL_CNT))
        else $error("queue count above depth");

    a_ready_has_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready != '0) |-> (r_count[w_sel] != '0))
        else $error("selected ready slot has an empty queue");
`endif

endmodule

[hdl/priority_event_dispatcher.sv]
// Top level of the priority event dispatcher: input and result registers.
//
//  channel   direction  handshake                    words
//  command   in         start high, busy low         i_command, i_priority_req, i_event_id
//  result    out        o_result_valid, one cycle    o_status, o_out_event,
//                                                    o_out_priority, o_any_ready
//
// One command is taken every cycle while busy is low; its result word comes out of the result register.
// The bitmap, ring state and memory port are updated in the cycle after the input
// register, and the result register is loaded alongside the event memory's registered read.
// Synchronous active-low reset clears the bitmap, ring heads and counts; busy is high
// during reset and in the first cycle after it. The receiver cannot stall the result.
`timescale 1ns / 1ps
module priority_event_dispatcher #(
    parameter int PRIORITIES  = ped_pkg::PRIORITIES_DEF,
    parameter int QUEUE_DEPTH = ped_pkg::QUEUE_DEPTH_DEF,
    parameter int EVENT_BITS  = ped_pkg::EVENT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ped_pkg::CMD_W-1:0]      i_command,
    input  logic [ped_pkg::PRIO_REQ_W-1:0] i_priority_req,
    input  logic [ped_pkg::EVENT_ID_W-1:0] i_event_id,
    output logic                           o_result_valid,
    output logic [ped_pkg::STATUS_W-1:0]   o_status,
    output logic [ped_pkg::EVENT_ID_W-1:0] o_out_event,
    output logic [ped_pkg::PRIO_REQ_W-1:0] o_out_priority,
    output logic                           o_any_ready
);
    import ped_pkg::*;

    localparam int STORE_DEPTH = PRIORITIES * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int EV_W        = (EVENT_BITS > EVENT_ID_W) ? EVENT_BITS : EVENT_ID_W;

    logic                  r_busy;
    logic                  r_in_valid;
    logic [CMD_W-1:0]      r_command;
    logic [PRIO_REQ_W-1:0] r_priority_req;
    logic [EVENT_ID_W-1:0] r_event_id;
    logic                  r_res_valid;
    t_result               r_res;

    logic                  w_wr_en;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic [EVENT_BITS-1:0] w_wr_data;
    logic                  w_rd_en;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [EVENT_BITS-1:0] w_rd_data;
    logic [EV_W-1:0]       w_rd_wide;
    t_result               w_res;

    // Hold off commands for one cycle out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    // Capture the command word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_command      <= i_command;
            r_priority_req <= i_priority_req;
            r_event_id     <= i_event_id;
        end
    end

    ped_queue_ctrl #(
        .PRIORITIES  (PRIORITIES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .EVENT_BITS  (EVENT_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_in_valid),
        .i_command      (r_command),
        .i_priority_req (r_priority_req),
        .i_event_id     (r_event_id),
        .o_wr_en        (w_wr_en),
        .o_wr_addr      (w_wr_addr),
        .o_wr_data      (w_wr_data),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .o_res          (w_res)
    );

    ped_event_store #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (EVENT_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Register the result word alongside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_res <= w_res;
        end
    end

    // Drive the result ports; the event field is zero unless fetched
    assign w_rd_wide      = EV_W'(w_rd_data);
    assign o_result_valid = r_res_valid;
    assign o_status       = r_res.status;
    assign o_out_event    = (r_res.status == ST_FETCHED) ? w_rd_wide[EVENT_ID_W-1:0] : '0;
    assign o_out_priority = r_res.out_priority;
    assign o_any_ready    = r_res.any_ready;

endmodule

[test/ped_dispatch_checker.sv]
// Checker for the priority event dispatcher: tracks the slot queues and compares result words.
`timescale 1ns / 1ps
module ped_dispatch_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [ped_pkg::CMD_W-1:0]      i_command,
    input  logic [ped_pkg::PRIO_REQ_W-1:0] i_priority_req,
    input  logic [ped_pkg::EVENT_ID_W-1:0] i_event_id,
    input  logic                           i_result_valid,
    input  logic [ped_pkg::STATUS_W-1:0]   i_status,
    input  logic [ped_pkg::EVENT_ID_W-1:0] i_out_event,
    input  logic [ped_pkg::PRIO_REQ_W-1:0] i_out_priority,
    input  logic                           i_any_ready,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_commands,
    output int                             o_fetched,
    output int                             o_dropped,
    output int                             o_empty
);
    import ped_pkg::*;

    localparam int SLOTS = PRIORITIES_DEF;
    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int EVT_W = EVENT_BITS_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [EVENT_ID_W-1:0] evt;
        logic [PRIO_REQ_W-1:0] prio;
        logic                  any_ready;
    } t_outcome;

    // Own copy of the dispatcher state
    logic [SLOTS-1:0]       slot_ready;
    logic [EVENT_ID_W-1:0]  slot_events [SLOTS][DEPTH];
    int                     slot_head   [SLOTS];
    int                     slot_fill   [SLOTS];

    t_outcome               outcome_q [$];

    // Apply one command to the slot queues and return the word it should produce
    function automatic t_outcome predict_dispatch(logic [CMD_W-1:0] cmd,
                                                  logic [PRIO_REQ_W-1:0] prio,
                                                  logic [EVENT_ID_W-1:0] ev);
        t_outcome res;
        int       slot;
        int       pos;
        int       top;
        res  = '0;
        res.status = ST_EMPTY;
        slot = int'(prio);
        if (cmd == CMD_POST || cmd == CMD_POST_AHEAD) begin
            if (slot >= SLOTS || slot_fill[slot] >= DEPTH) begin
                res.status = ST_DROPPED;
            end else begin
                if (cmd == CMD_POST_AHEAD) begin
                    slot_head[slot] = (slot_head[slot] + DEPTH - 1) % DEPTH;
                    pos = slot_head[slot];
                end else begin
                    pos = (slot_head[slot] + slot_fill[slot]) % DEPTH;
                end
                slot_events[slot][pos] = EVENT_ID_W'(32'(ev) & ((1 << EVT_W) - 1));
                slot_fill[slot]++;
                slot_ready[slot] = 1'b1;
                res.status = ST_QUEUED;
            end
        end else if (cmd == CMD_FETCH && slot_ready != '0) begin
            // highest set bit wins
            top = 0;
            for (int p = SLOTS - 1; p >= 0; p--) begin
                if (slot_ready[p] && top == 0 && res.status != ST_FETCHED) begin
                    top = p;
                    res.status = ST_FETCHED;
                end
            end
            res.evt  = slot_events[top][slot_head[top]];
            res.prio = top[PRIO_REQ_W-1:0];
            slot_head[top] = (slot_head[top] + 1) % DEPTH;
            if (slot_fill[top] > 0) slot_fill[top]--;
            if (slot_fill[top] == 0) slot_ready[top] = 1'b0;
        end
        res.any_ready = |slot_ready;
        return res;
    endfunction

    // Predict on acceptance, compare on each result strobe
    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome pred;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            slot_ready = '0;
            for (int s = 0; s < SLOTS; s++) begin
                slot_head[s] = 0;
                slot_fill[s] = 0;
            end
            outcome_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            o_commands   <= 0;
            o_fetched    <= 0;
            o_dropped    <= 0;
            o_empty      <= 0;
        end else begin
            if (i_start && !i_busy) begin
                pred = predict_dispatch(i_command, i_priority_req, i_event_id);
                outcome_q.push_back(pred);
                o_commands <= o_commands + 1;
                if (pred.status == ST_FETCHED) o_fetched <= o_fetched + 1;
                if (pred.status == ST_DROPPED) o_dropped <= o_dropped + 1;
                if (pred.status == ST_EMPTY)   o_empty   <= o_empty + 1;
            end
            if (i_result_valid) begin
                if (outcome_q.size() == 0) begin
                    $error("result word with no command outstanding (status %0d)", i_status);
                    errs++;
                end else begin
                    want = outcome_q.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        errs++;
                    end
                    if (i_out_event !== want.evt) begin
                        $error("out_event: expected %0d, got %0d", want.evt, i_out_event);
                        errs++;
                    end
                    if (i_out_priority !== want.prio) begin
                        $error("out_priority: expected %0d, got %0d", want.prio,
                               i_out_priority);
                        errs++;
                    end
                    if (i_any_ready !== want.any_ready) begin
                        $error("any_ready: expected %0d, got %0d", want.any_ready,
                               i_any_ready);
                        errs++;
                    end
                end
            end
            // Fold all mismatches of this word into one count update
            if (errs != 0) o_fail_count <= o_fail_count + errs;
            o_pending <= outcome_q.size();
        end
    end

endmodule

[test/tb_priority_event_dispatcher.sv]
// Testbench top for the priority event dispatcher: clock, reset, command stimulus, verdict.
`timescale 1ns / 1ps
module tb_priority_event_dispatcher;
    import ped_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               CYCLE_LIMIT = 200000;
    localparam int               RANDOM_WORDS = 1850;
    localparam int               SEGMENT_WORDS = 150;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [CMD_W-1:0]       i_command;
    logic [PRIO_REQ_W-1:0]  i_priority_req;
    logic [EVENT_ID_W-1:0]  i_event_id;
    logic                   o_result_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [EVENT_ID_W-1:0]  o_out_event;
    logic [PRIO_REQ_W-1:0]  o_out_priority;
    logic                   o_any_ready;

    int fail_count;
    int pending;
    int commands;
    int fetched;
    int dropped;
    int empty_answers;
    int idle_pct;
    int cycle_count = 0;

    priority_event_dispatcher uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_priority_req (i_priority_req),
        .i_event_id     (i_event_id),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_out_event    (o_out_event),
        .o_out_priority (o_out_priority),
        .o_any_ready    (o_any_ready)
    );

    ped_dispatch_checker dispatch_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_command      (i_command),
        .i_priority_req (i_priority_req),
        .i_event_id     (i_event_id),
        .i_result_valid (o_result_valid),
        .i_status       (o_status),
        .i_out_event    (o_out_event),
        .i_out_priority (o_out_priority),
        .i_any_ready    (o_any_ready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_commands     (commands),
        .o_fetched      (fetched),
        .o_dropped      (dropped),
        .o_empty        (empty_answers)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("priority_event_dispatcher regression: fail");
            $finish;
        end
    end

    // Offer one command word after a random idle gap; return once it is taken
    task automatic issue_command(logic [CMD_W-1:0] cmd, logic [PRIO_REQ_W-1:0] prio,
                                 logic [EVENT_ID_W-1:0] ev);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start          <= 1'b0;
            i_command      <= CMD_W'($urandom);
            i_priority_req <= PRIO_REQ_W'($urandom);
            i_event_id     <= EVENT_ID_W'($urandom);
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_command      <= cmd;
        i_priority_req <= prio;
        i_event_id     <= ev;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Hold off the sender until every outstanding result word has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [CMD_W-1:0]      cmd;
        logic [PRIO_REQ_W-1:0] prio;
        int                    fetch_pct;
        int                    base;
        int                    roll;
        logic                  narrow;
        int                    segment;
        int                    sent;

        idle_pct       = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_command      = CMD_POST;
        i_priority_req = '0;
        i_event_id     = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty fetch, unused command, both ends of slots and ids, full queue
        issue_command(CMD_FETCH, 5'd31, 8'hFF);
        issue_command(CMD_UNUSED, 5'd31, 8'hFF);
        issue_command(CMD_POST, 5'd31, 8'hFF);
        issue_command(CMD_POST_AHEAD, 5'd0, 8'h00);
        issue_command(CMD_POST, 5'd0, 8'h5A);
        issue_command(CMD_UNUSED, 5'd0, 8'h00);
        for (int i = 0; i < 7; i++) begin
            issue_command(i[0] ? CMD_POST_AHEAD : CMD_POST, 5'd31, EVENT_ID_W'(8'h80 | i));
        end
        issue_command(CMD_POST, 5'd31, 8'h11);
        issue_command(CMD_POST_AHEAD, 5'd31, 8'h22);
        repeat (10) issue_command(CMD_FETCH, 5'd0, 8'h00);
        drain_results();

        // Random segments with varying fetch share, slot spread and idle rate
        sent    = 0;
        segment = 0;
        while (sent < RANDOM_WORDS) begin
            case (segment % 4)
                0: idle_pct = 0;
                1: idle_pct = 58;
                2: idle_pct = 19;
                default: idle_pct = 0;
            endcase
            fetch_pct = int'($urandom_range(15, 70));
            narrow    = 1'($urandom_range(0, 1));
            base      = int'($urandom_range(0, 28));
            for (int k = 0; k < SEGMENT_WORDS && sent < RANDOM_WORDS; k++) begin
                roll = int'($urandom_range(0, 99));
                if (roll < 4) cmd = CMD_UNUSED;
                else if (roll < 4 + fetch_pct) cmd = CMD_FETCH;
                else if ($urandom_range(0, 2) == 0) cmd = CMD_POST_AHEAD;
                else cmd = CMD_POST;
                if ($urandom_range(0, 19) == 0) prio = $urandom_range(0, 1) ? 5'd31 : 5'd0;
                else if (narrow) prio = PRIO_REQ_W'(base + int'($urandom_range(0, 3)));
                else prio = PRIO_REQ_W'($urandom_range(0, 31));
                issue_command(cmd, prio, EVENT_ID_W'($urandom_range(0, 255)));
                sent++;
            end
            if (segment % 3 == 1) drain_results();
            segment++;
        end

        // Wait out the remaining results plus the pipeline depth
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Ran %0d command words: %0d fetched, %0d dropped on full queues,",
                 commands, fetched, dropped);
        $display("and %0d answered with nothing ready or an unused command.", empty_answers);
        if (fail_count == 0 && pending == 0) begin
            $display("priority_event_dispatcher regression: pass");
        end else begin
            $display("priority_event_dispatcher regression: fail");
        end
        $finish;
    end

endmodule
